[sv/sdsh_pkg.sv]
package sdsh_pkg;

  // Block size of a write and width of the shared byte counter
  localparam int BLOCK_BYTES = 512;
  localparam int LEN_W       = 10;
  localparam int CNT_W       = ($clog2(BLOCK_BYTES + 1) > LEN_W) ?
                               $clog2(BLOCK_BYTES + 1) : LEN_W;

  // Request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_CARD  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Transfer kinds
  localparam logic [2:0] KIND_CMD      = 3'd0;
  localparam logic [2:0] KIND_CMD_READ = 3'd1;
  localparam logic [2:0] KIND_READ     = 3'd2;
  localparam logic [2:0] KIND_WR_FE    = 3'd3;
  localparam logic [2:0] KIND_WR_FC    = 3'd4;
  localparam logic [2:0] KIND_STOP     = 3'd5;

  // Bus bytes
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] CMD_START   = 8'h40;
  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] TOKEN_MULTI = 8'hFC;
  localparam logic [7:0] TOKEN_STOP  = 8'hFD;
  localparam logic [5:0] CMD_STOP_INDEX = 6'd12;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD_DESEL, PH_CMD_READY, PH_CMD_SEND, PH_CMD_POLL,
    PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC1, PH_RD_CRC2,
    PH_WR_BUSY, PH_WR_TOKEN, PH_WR_NEED, PH_WR_SENT, PH_WR_TAIL,
    PH_ST_BUSY, PH_ST_TOKEN
  } phase_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [5:0]       cmd_index;
    logic [31:0]      cmd_arg;
    logic [7:0]       cmd_crc;
    logic [2:0]       transfer_kind;
    logic [LEN_W-1:0] read_length;
    logic [7:0]       card_byte;
    logic [7:0]       write_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       chip_select;
    logic [7:0] r1_response;
    logic       r1_valid;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       rx_last;
    logic       write_byte_request;
    logic       done_res;
  } result_t;

endpackage

[sv/sdsh_ctrl.sv]
module sdsh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  sdsh_pkg::item_t  item,
  output sdsh_pkg::result_t result
);

  sdsh_pkg::phase_t              phase_r, phase_nxt;
  logic [sdsh_pkg::CNT_W-1:0]    byte_count_r, byte_count_nxt;
  logic [sdsh_pkg::CNT_W-1:0]    count_inc;
  logic [5:0]                    saved_index_r, saved_index_nxt;
  logic [31:0]                   saved_arg_r, saved_arg_nxt;
  logic [7:0]                    saved_crc_r, saved_crc_nxt;
  logic [2:0]                    saved_kind_r, saved_kind_nxt;
  logic [sdsh_pkg::LEN_W-1:0]    saved_len_r, saved_len_nxt;
  logic                          select_r, select_nxt;
  logic [sdsh_pkg::CNT_W-1:0]    frame_len;
  logic [7:0]                    frame_byte;
  sdsh_pkg::result_t             res;

  // Hold sequencer state; advance only when a word is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= sdsh_pkg::PH_IDLE;
      byte_count_r  <= '0;
      saved_index_r <= '0;
      saved_arg_r   <= '0;
      saved_crc_r   <= '0;
      saved_kind_r  <= '0;
      saved_len_r   <= '0;
      select_r      <= 1'b0;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      byte_count_r  <= byte_count_nxt;
      saved_index_r <= saved_index_nxt;
      saved_arg_r   <= saved_arg_nxt;
      saved_crc_r   <= saved_crc_nxt;
      saved_kind_r  <= saved_kind_nxt;
      saved_len_r   <= saved_len_nxt;
      select_r      <= select_nxt;
    end
  end

  assign count_inc = byte_count_r + 1'b1;
  assign frame_len = (saved_index_r == sdsh_pkg::CMD_STOP_INDEX) ?
                     sdsh_pkg::CNT_W'(7) : sdsh_pkg::CNT_W'(6);

  // Pick the command frame byte at the current position
  always_comb begin
    case (byte_count_r[2:0])
      3'd1:    frame_byte = saved_arg_r[31:24];
      3'd2:    frame_byte = saved_arg_r[23:16];
      3'd3:    frame_byte = saved_arg_r[15:8];
      3'd4:    frame_byte = saved_arg_r[7:0];
      3'd5:    frame_byte = saved_crc_r;
      default: frame_byte = sdsh_pkg::IDLE_BYTE;
    endcase
  end

  // Next state and result for one request word
  always_comb begin
    phase_nxt       = phase_r;
    byte_count_nxt  = byte_count_r;
    saved_index_nxt = saved_index_r;
    saved_arg_nxt   = saved_arg_r;
    saved_crc_nxt   = saved_crc_r;
    saved_kind_nxt  = saved_kind_r;
    saved_len_nxt   = saved_len_r;
    select_nxt      = select_r;
    res             = '0;

    case (item.req_type)
      sdsh_pkg::REQ_START: begin
        if (phase_r == sdsh_pkg::PH_IDLE && item.transfer_kind <= sdsh_pkg::KIND_STOP) begin
          saved_index_nxt = item.cmd_index;
          saved_arg_nxt   = item.cmd_arg;
          saved_crc_nxt   = item.cmd_crc;
          saved_kind_nxt  = item.transfer_kind;
          saved_len_nxt   = item.read_length;
          byte_count_nxt  = '0;
          res.tx_byte     = sdsh_pkg::IDLE_BYTE;
          res.tx_valid    = 1'b1;
          if (item.transfer_kind <= sdsh_pkg::KIND_CMD_READ) begin
            select_nxt = 1'b0;
            phase_nxt  = sdsh_pkg::PH_CMD_DESEL;
          end else if (item.transfer_kind == sdsh_pkg::KIND_READ) begin
            phase_nxt = sdsh_pkg::PH_RD_TOKEN;
          end else if (item.transfer_kind <= sdsh_pkg::KIND_WR_FC) begin
            phase_nxt = sdsh_pkg::PH_WR_BUSY;
          end else begin
            phase_nxt = sdsh_pkg::PH_ST_BUSY;
          end
        end
      end

      sdsh_pkg::REQ_CARD: begin
        case (phase_r)
          sdsh_pkg::PH_CMD_DESEL: begin
            select_nxt   = 1'b1;
            res.tx_byte  = sdsh_pkg::IDLE_BYTE;
            res.tx_valid = 1'b1;
            phase_nxt    = sdsh_pkg::PH_CMD_READY;
          end
          sdsh_pkg::PH_CMD_READY: begin
            res.tx_valid = 1'b1;
            if (item.card_byte == sdsh_pkg::IDLE_BYTE) begin
              res.tx_byte    = sdsh_pkg::CMD_START | {2'b00, saved_index_r};
              byte_count_nxt = sdsh_pkg::CNT_W'(1);
              phase_nxt      = sdsh_pkg::PH_CMD_SEND;
            end else begin
              res.tx_byte = sdsh_pkg::IDLE_BYTE;
            end
          end
          sdsh_pkg::PH_CMD_SEND: begin
            res.tx_valid = 1'b1;
            if (byte_count_r < frame_len) begin
              res.tx_byte    = frame_byte;
              byte_count_nxt = count_inc;
            end else begin
              res.tx_byte = sdsh_pkg::IDLE_BYTE;
              phase_nxt   = sdsh_pkg::PH_CMD_POLL;
            end
          end
          sdsh_pkg::PH_CMD_POLL: begin
            if (!item.card_byte[7]) begin
              res.r1_response = item.card_byte;
              res.r1_valid    = 1'b1;
              if (saved_kind_r == sdsh_pkg::KIND_CMD_READ) begin
                res.tx_byte  = sdsh_pkg::IDLE_BYTE;
                res.tx_valid = 1'b1;
                phase_nxt    = sdsh_pkg::PH_RD_TOKEN;
              end else begin
                res.done_res = 1'b1;
                phase_nxt    = sdsh_pkg::PH_IDLE;
              end
            end else begin
              res.tx_byte  = sdsh_pkg::IDLE_BYTE;
              res.tx_valid = 1'b1;
            end
          end
          sdsh_pkg::PH_RD_TOKEN: begin
            res.tx_byte  = sdsh_pkg::IDLE_BYTE;
            res.tx_valid = 1'b1;
            if (item.card_byte == sdsh_pkg::TOKEN_START) begin
              byte_count_nxt = '0;
              phase_nxt = (saved_len_r == '0) ? sdsh_pkg::PH_RD_CRC1 : sdsh_pkg::PH_RD_DATA;
            end
          end
          sdsh_pkg::PH_RD_DATA: begin
            res.rx_data    = item.card_byte;
            res.rx_valid   = 1'b1;
            res.tx_byte    = sdsh_pkg::IDLE_BYTE;
            res.tx_valid   = 1'b1;
            byte_count_nxt = count_inc;
            if (count_inc >= sdsh_pkg::CNT_W'(saved_len_r)) begin
              res.rx_last = 1'b1;
              phase_nxt   = sdsh_pkg::PH_RD_CRC1;
            end
          end
          sdsh_pkg::PH_RD_CRC1: begin
            res.tx_byte  = sdsh_pkg::IDLE_BYTE;
            res.tx_valid = 1'b1;
            phase_nxt    = sdsh_pkg::PH_RD_CRC2;
          end
          sdsh_pkg::PH_RD_CRC2: begin
            res.done_res = 1'b1;
            phase_nxt    = sdsh_pkg::PH_IDLE;
          end
          sdsh_pkg::PH_WR_BUSY: begin
            res.tx_valid = 1'b1;
            if (item.card_byte == sdsh_pkg::IDLE_BYTE) begin
              res.tx_byte = (saved_kind_r == sdsh_pkg::KIND_WR_FE) ?
                            sdsh_pkg::TOKEN_START : sdsh_pkg::TOKEN_MULTI;
              phase_nxt   = sdsh_pkg::PH_WR_TOKEN;
            end else begin
              res.tx_byte = sdsh_pkg::IDLE_BYTE;
            end
          end
          sdsh_pkg::PH_WR_TOKEN: begin
            byte_count_nxt         = '0;
            res.write_byte_request = 1'b1;
            phase_nxt              = sdsh_pkg::PH_WR_NEED;
          end
          sdsh_pkg::PH_WR_SENT: begin
            if (byte_count_r >= sdsh_pkg::CNT_W'(sdsh_pkg::BLOCK_BYTES)) begin
              res.tx_byte    = sdsh_pkg::IDLE_BYTE;
              res.tx_valid   = 1'b1;
              byte_count_nxt = sdsh_pkg::CNT_W'(1);
              phase_nxt      = sdsh_pkg::PH_WR_TAIL;
            end else begin
              res.write_byte_request = 1'b1;
              phase_nxt              = sdsh_pkg::PH_WR_NEED;
            end
          end
          sdsh_pkg::PH_WR_TAIL: begin
            if (byte_count_r < sdsh_pkg::CNT_W'(3)) begin
              res.tx_byte    = sdsh_pkg::IDLE_BYTE;
              res.tx_valid   = 1'b1;
              byte_count_nxt = count_inc;
            end else begin
              res.done_res = 1'b1;
              phase_nxt    = sdsh_pkg::PH_IDLE;
            end
          end
          sdsh_pkg::PH_ST_BUSY: begin
            res.tx_valid = 1'b1;
            if (item.card_byte == sdsh_pkg::IDLE_BYTE) begin
              res.tx_byte = sdsh_pkg::TOKEN_STOP;
              phase_nxt   = sdsh_pkg::PH_ST_TOKEN;
            end else begin
              res.tx_byte = sdsh_pkg::IDLE_BYTE;
            end
          end
          sdsh_pkg::PH_ST_TOKEN: begin
            res.done_res = 1'b1;
            phase_nxt    = sdsh_pkg::PH_IDLE;
          end
          default: begin
          end
        endcase
      end

      sdsh_pkg::REQ_WRITE: begin
        if (phase_r == sdsh_pkg::PH_WR_NEED) begin
          res.tx_byte    = item.write_byte;
          res.tx_valid   = 1'b1;
          byte_count_nxt = count_inc;
          phase_nxt      = sdsh_pkg::PH_WR_SENT;
        end
      end

      default: begin
      end
    endcase

    res.chip_select = select_nxt;
  end

  assign result = res;

  // A completed transfer leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.done_res |=> phase_r == sdsh_pkg::PH_IDLE)
    else $error("done without returning to idle");

  // A host byte request parks the sequencer waiting for that byte
  a_req_wait: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.write_byte_request |=> phase_r == sdsh_pkg::PH_WR_NEED)
    else $error("write request without waiting for host byte");

  // R1 is reported only with bit 7 clear
  a_r1_bit7: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.r1_valid |-> !res.r1_response[7])
    else $error("R1 reported with busy bit set");

  // The last flag marks a data byte
  a_rx_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.rx_last |-> res.rx_valid)
    else $error("rx_last without data byte");

  // State moves only on a processed word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(phase_r) && $stable(byte_count_r) && $stable(select_r))
    else $error("sequencer state changed without a word");

endmodule

[sv/sd_spi_host_sequencer.sv]
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall   | request word: type, command, kind, bytes
// out_    | output    | out_valid / out_stall | exchange byte, select, R1, read data, flags
//
// Every request word yields exactly one result word; one word per cycle sustained while out_stall is low.
// The path is an input register, then the sequencer step, whose
// phase and counter update land together with the output register.
// Reset (rst_n low, synchronous) idles the sequencer, deselects the card and
// empties both registers. out_stall holds the result and backs up into in_stall
// only once the input register is also full.
module sd_spi_host_sequencer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic [5:0]                 in_cmd_index,
  input  logic [31:0]                in_cmd_arg,
  input  logic [7:0]                 in_cmd_crc,
  input  logic [2:0]                 in_transfer_kind,
  input  logic [sdsh_pkg::LEN_W-1:0] in_read_length,
  input  logic [7:0]                 in_card_byte,
  input  logic [7:0]                 in_write_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_tx_byte,
  output logic                       out_tx_valid,
  output logic                       out_chip_select,
  output logic [7:0]                 out_r1_response,
  output logic                       out_r1_valid,
  output logic [7:0]                 out_rx_data,
  output logic                       out_rx_valid,
  output logic                       out_rx_last,
  output logic                       out_write_byte_request,
  output logic                       out_done_res
);

  logic              in_valid_r;
  sdsh_pkg::item_t   in_item_r;
  logic              out_valid_r;
  sdsh_pkg::result_t out_res_r;
  sdsh_pkg::result_t step_res;
  logic              out_free;
  logic              fire;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  // Input register: take a word whenever the held one moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r.req_type      <= in_req_type;
      in_item_r.cmd_index     <= in_cmd_index;
      in_item_r.cmd_arg       <= in_cmd_arg;
      in_item_r.cmd_crc       <= in_cmd_crc;
      in_item_r.transfer_kind <= in_transfer_kind;
      in_item_r.read_length   <= in_read_length;
      in_item_r.card_byte     <= in_card_byte;
      in_item_r.write_byte    <= in_write_byte;
    end
  end

  sdsh_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_item_r),
    .result (step_res)
  );

  // Output register: load on a step, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_tx_byte            = out_res_r.tx_byte;
  assign out_tx_valid           = out_res_r.tx_valid;
  assign out_chip_select        = out_res_r.chip_select;
  assign out_r1_response        = out_res_r.r1_response;
  assign out_r1_valid           = out_res_r.r1_valid;
  assign out_rx_data            = out_res_r.rx_data;
  assign out_rx_valid           = out_res_r.rx_valid;
  assign out_rx_last            = out_res_r.rx_last;
  assign out_write_byte_request = out_res_r.write_byte_request;
  assign out_done_res           = out_res_r.done_res;

endmodule
